/* rtl/core/orle_pkg.sv */
`timescale 1ns / 1ps

package orle_pkg;

   localparam int DEPTH_DEF = 16;
   localparam int VAL_W     = 32;
   localparam int LEN_W     = 5;

   typedef enum logic [1:0] {
      OP_INS_FRONT = 2'd0,
      OP_INS_BACK  = 2'd1,
      OP_DELETE    = 2'd2,
      OP_DUMP      = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      STAT_OK        = 2'd0,
      STAT_FULL      = 2'd1,
      STAT_EMPTY     = 2'd2,
      STAT_NOT_FOUND = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_SEARCH,
      S_SHIFT,
      S_DUMP,
      S_REPORT
   } state_type;

   typedef struct packed {
      opcode_type               opcode;
      logic signed [VAL_W-1:0]  value;
   } req_type;

   typedef struct packed {
      status_type               status;
      logic signed [VAL_W-1:0]  element;
      logic                     last_of_run;
      logic [LEN_W-1:0]         length;
   } rsp_type;

endpackage

/* rtl/core/ordered_ring_list_engine_core.sv */
`timescale 1ns / 1ps

// Ordered ring list engine: a list of up to DEPTH signed 32-bit values kept
// in a circular buffer held in one synchronous RAM.
// Request channel (req_valid/req_ready/req_payload) carries an opcode and a
// value: insert at front, insert at back, delete first match, dump.
// Response channel (rsp_valid/rsp_ready/rsp_payload) returns one item per
// operation, or one item per element for a dump, the final one flagged by
// last_of_run. Each item reports status and the list length afterwards.
// One operation is worked at a time; req_ready is high only between them.
// Inserts and empty-list cases answer from the execute state; a dump first
// reads the front element, then sends one element per cycle while the
// receiver takes them; delete walks the list at one RAM read per cycle, then
// closes the gap at one read and one write per cycle, and reports from
// S_REPORT whether the value was found.
// The RAM port (one read, one write per cycle) sets the pace of these walks.
// Synchronous reset empties the list at once; no clearing pass is needed.
// A stalled receiver holds the response register; the engine waits with it,
// and a finished result may wait there while the next request is accepted.
module ordered_ring_list_engine_core #(
   parameter int DEPTH = orle_pkg::DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  orle_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output orle_pkg::rsp_type rsp_payload
);
   import orle_pkg::*;

   localparam int CW = $clog2(DEPTH + 1);
   localparam int IW = $clog2(DEPTH);

   state_type                state_ff, state_in;
   opcode_type               op_ff, op_in;
   logic signed [VAL_W-1:0]  value_ff, value_in;
   logic [CW-1:0]            count_ff, count_in;
   logic [IW-1:0]            front_ff, front_in;
   logic [CW-1:0]            idx_ff, idx_in;
   status_type               st_ff, st_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  rsp_ff;
   logic [VAL_W-1:0]         rdata_ff;
   logic [VAL_W-1:0]         mem [DEPTH];

   logic                     emit;
   rsp_type                  emit_rsp;
   logic                     rd_en, wr_en;
   logic [IW-1:0]            rd_addr, wr_addr;
   logic [VAL_W-1:0]         wr_data;
   logic                     out_free;
   logic                     count_zero, count_full, hit, at_last;

   function automatic logic [IW-1:0] pos_of(input logic [IW-1:0] f,
                                            input logic [CW-1:0] k);
      logic [CW:0] s;
      s = (CW+1)'(f) + (CW+1)'(k);
      if (s >= (CW+1)'(DEPTH))
         s = s - (CW+1)'(DEPTH);
      return s[IW-1:0];
   endfunction

   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign count_zero = (count_ff == '0);
   assign count_full = (count_ff == CW'(DEPTH));
   assign hit        = (rdata_ff == value_ff);
   assign at_last    = ((idx_ff + 1'b1) == count_ff);

   assign req_ready   = (state_ff == S_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid)
               state_in = S_EXEC;
         end
         S_EXEC: begin
            case (op_ff)
               OP_DELETE: begin
                  if (!count_zero)
                     state_in = S_SEARCH;
                  else if (out_free)
                     state_in = S_IDLE;
               end
               OP_DUMP: begin
                  if (!count_zero)
                     state_in = S_DUMP;
                  else if (out_free)
                     state_in = S_IDLE;
               end
               default: begin
                  if (out_free)
                     state_in = S_IDLE;
               end
            endcase
         end
         S_SEARCH: begin
            if (hit)
               state_in = S_SHIFT;
            else if (at_last)
               state_in = S_REPORT;
         end
         S_SHIFT: begin
            if (idx_ff == count_ff)
               state_in = S_REPORT;
         end
         S_DUMP: begin
            if (out_free && at_last)
               state_in = S_IDLE;
         end
         S_REPORT: begin
            if (out_free)
               state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // datapath and RAM control
   always_comb begin
      op_in    = op_ff;
      value_in = value_ff;
      count_in = count_ff;
      front_in = front_ff;
      idx_in   = idx_ff;
      st_in    = st_ff;
      emit     = 1'b0;
      emit_rsp = '{status: STAT_OK, element: value_ff, last_of_run: 1'b1,
                   length: LEN_W'(count_ff)};
      rd_en    = 1'b0;
      rd_addr  = pos_of(front_ff, idx_ff + 1'b1);
      wr_en    = 1'b0;
      wr_addr  = front_ff;
      wr_data  = value_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in    = req_payload.opcode;
               value_in = req_payload.value;
            end
         end
         S_EXEC: begin
            case (op_ff)
               OP_INS_FRONT, OP_INS_BACK: begin
                  if (out_free) begin
                     emit = 1'b1;
                     if (count_full) begin
                        emit_rsp.status = STAT_FULL;
                     end else begin
                        wr_en = 1'b1;
                        if (op_ff == OP_INS_FRONT) begin
                           front_in = (front_ff == '0) ? IW'(DEPTH - 1)
                                                       : front_ff - 1'b1;
                           wr_addr  = front_in;
                        end else begin
                           wr_addr = pos_of(front_ff, count_ff);
                        end
                        count_in        = count_ff + 1'b1;
                        emit_rsp.length = LEN_W'(count_in);
                     end
                  end
               end
               default: begin
                  if (count_zero) begin
                     emit            = out_free;
                     emit_rsp.status = STAT_EMPTY;
                     if (op_ff == OP_DUMP)
                        emit_rsp.element = '0;
                  end else begin
                     // prime the walk with the front element
                     rd_en   = 1'b1;
                     rd_addr = front_ff;
                     idx_in  = '0;
                  end
               end
            endcase
         end
         S_SEARCH: begin
            if (hit || !at_last) begin
               // fetch next element: walk on, or first element to pull forward
               rd_en  = 1'b1;
               idx_in = idx_ff + 1'b1;
            end else begin
               st_in = STAT_NOT_FOUND;
            end
         end
         S_SHIFT: begin
            if (idx_ff == count_ff) begin
               count_in = count_ff - 1'b1;
               st_in    = STAT_OK;
            end else begin
               // move element idx one slot toward the front
               wr_en   = 1'b1;
               wr_addr = pos_of(front_ff, idx_ff - 1'b1);
               wr_data = rdata_ff;
               rd_en   = 1'b1;
               idx_in  = idx_ff + 1'b1;
            end
         end
         S_DUMP: begin
            if (out_free) begin
               emit                 = 1'b1;
               emit_rsp.element     = rdata_ff;
               emit_rsp.last_of_run = at_last;
               if (!at_last) begin
                  rd_en  = 1'b1;
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         S_REPORT: begin
            emit            = out_free;
            emit_rsp.status = st_ff;
         end
         default: ;
      endcase
      rsp_valid_in = emit || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         front_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         front_ff     <= front_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff    <= op_in;
      value_ff <= value_in;
      idx_ff   <= idx_in;
      st_ff    <= st_in;
      if (emit)
         rsp_ff <= emit_rsp;
   end

   // list RAM: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en)
         mem[wr_addr] <= wr_data;
      if (rd_en)
         rdata_ff <= mem[rd_addr];
   end

`ifndef NO_ASSERTIONS
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("list count exceeds depth");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (count_ff == $past(count_ff)) ||
                        (count_ff == $past(count_ff) + 1'b1) ||
                        (count_ff == $past(count_ff) - 1'b1))
      else $error("list count moved by more than one");

   a_no_write_on_walk: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SEARCH || state_ff == S_DUMP) |-> !wr_en)
      else $error("RAM written during search or dump");

   a_dump_index: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DUMP || state_ff == S_SEARCH) |-> idx_ff < count_ff)
      else $error("walk index beyond list");

   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> state_ff == S_EXEC)
      else $error("accepted item not executed");
`endif

endmodule

/* tb/tb_ordered_ring_list_engine_core.sv */
`timescale 1ns / 1ps

module tb_ordered_ring_list_engine_core;
   import orle_pkg::*;

   localparam int STALL_LIMIT   = 2000;
   localparam int DRAIN_LIMIT   = 1000;
   localparam int SETTLE_CYCLES = 2 * DEPTH_DEF + 8;
   localparam int RANDOM_ITEMS  = 300;
   localparam int HOLD_AT       = 140;
   localparam int HOLD_CYCLES   = 80;
   localparam int CALM_FROM     = 180;
   localparam int CALM_TO       = 240;
   localparam int POOL_SIZE     = 24;

   typedef logic signed [VAL_W-1:0] value_type;

   // Mirror of the list contents plus the results still owed by the block.
   class list_scoreboard;
      value_type contents[$];
      rsp_type   due[$];
      int        errors;

      function int pending();
         return due.size();
      endfunction

      function void queue_result(status_type st, value_type el, logic last);
         rsp_type r;
         r.status      = st;
         r.element     = el;
         r.last_of_run = last;
         r.length      = LEN_W'(contents.size());
         due.push_back(r);
      endfunction

      function void note_request(req_type r);
         int hit;
         hit = -1;
         case (r.opcode)
            OP_INS_FRONT, OP_INS_BACK: begin
               if (contents.size() >= DEPTH_DEF) begin
                  queue_result(STAT_FULL, r.value, 1'b1);
               end else begin
                  if (r.opcode == OP_INS_FRONT) contents.push_front(r.value);
                  else contents.push_back(r.value);
                  queue_result(STAT_OK, r.value, 1'b1);
               end
            end
            OP_DELETE: begin
               foreach (contents[i]) if (hit < 0 && contents[i] == r.value) hit = i;
               if (contents.size() == 0) begin
                  queue_result(STAT_EMPTY, r.value, 1'b1);
               end else if (hit < 0) begin
                  queue_result(STAT_NOT_FOUND, r.value, 1'b1);
               end else begin
                  // later entries close the gap, order is kept
                  contents.delete(hit);
                  queue_result(STAT_OK, r.value, 1'b1);
               end
            end
            default: begin
               if (contents.size() == 0) queue_result(STAT_EMPTY, '0, 1'b1);
               else foreach (contents[i])
                  queue_result(STAT_OK, contents[i], i == contents.size() - 1);
            end
         endcase
      endfunction

      task report(string msg);
         errors++;
         $display("MISMATCH %s", msg);
      endtask

      task check_response(rsp_type got);
         rsp_type want;
         if (due.size() == 0) begin
            report($sformatf("unexpected item st=%0d el=%0d last=%0b len=%0d",
                             got.status, got.element, got.last_of_run, got.length));
         end else begin
            want = due.pop_front();
            if (got.status !== want.status || got.element !== want.element ||
                got.last_of_run !== want.last_of_run || got.length !== want.length)
               report($sformatf("got st=%0d el=%0d last=%0b len=%0d, want %0d %0d %0b %0d",
                                got.status, got.element, got.last_of_run, got.length,
                                want.status, want.element, want.last_of_run, want.length));
         end
      endtask
   endclass

   logic    clock       = 1'b0;
   logic    reset       = 1'b1;
   logic    req_valid   = 1'b0;
   logic    req_ready;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_ready   = 1'b0;
   rsp_type rsp_payload;

   list_scoreboard sb = new();
   int n_requests  = 0;
   int quiet_count = 0;

   always #5 clock = ~clock;

   ordered_ring_list_engine_core DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   function automatic bit calm_window();
      return n_requests >= CALM_FROM && n_requests < CALM_TO;
   endfunction

   function automatic value_type pick_value();
      case ($urandom_range(7))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return -1;
         3: return 0;
         4: return $urandom_range(7);
         default: return $urandom();
      endcase
   endfunction

   task automatic send_item(input opcode_type op, input value_type v);
      while (!calm_window() && $urandom_range(99) < 26) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= '{opcode: op, value: v};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      for (int c = 0; c < DRAIN_LIMIT && sb.pending() != 0; c++) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            sb.note_request(req_payload);
            n_requests <= n_requests + 1;
         end
         if (rsp_valid && rsp_ready) sb.check_response(rsp_payload);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            quiet_count <= 0;
         end else if (quiet_count >= STALL_LIMIT) begin
            $display("== FAIL ==");
            $finish;
         end else begin
            quiet_count <= quiet_count + 1;
         end
      end
   end

   // Result side: random stalls, one long hold-off, a stretch with none.
   initial begin
      bit held_off;
      held_off = 1'b0;
      wait (!reset);
      forever begin
         @(posedge clock);
         if (!held_off && n_requests >= HOLD_AT) begin
            held_off = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            rsp_ready <= calm_window() || $urandom_range(99) >= 26;
         end
      end
   end

   initial begin
      opcode_type op;
      value_type  v;
      value_type  recent[$];
      int         roll;
      bit         growing;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // empty list, then fill past capacity with duplicates and extremes
      send_item(OP_DUMP, 32'h0000_1234);
      send_item(OP_DELETE, -5);
      send_item(OP_INS_FRONT, 32'h8000_0000);
      send_item(OP_INS_BACK, 32'h7fff_ffff);
      for (int k = 0; k < 14; k++)
         send_item(k[0] ? OP_INS_BACK : OP_INS_FRONT, (k % 5 == 0) ? -1 : $urandom());
      send_item(OP_INS_FRONT, 32'h0bad_0001);
      send_item(OP_INS_BACK, 32'h0bad_0002);
      send_item(OP_DUMP, $urandom());
      send_item(OP_DELETE, 32'h0000_3039);
      send_item(OP_DELETE, -1);
      send_item(OP_DELETE, 32'h8000_0000);
      send_item(OP_DELETE, 32'h7fff_ffff);
      send_item(OP_DUMP, 0);
      wait_drained();

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == 100) wait_drained();
         // alternate phases that grow toward full and shrink toward empty
         growing = (n / 30) % 2 == 0;
         roll = $urandom_range(99);
         if (roll < 15) op = OP_DUMP;
         else if (roll < (growing ? 85 : 40))
            op = $urandom_range(1) ? OP_INS_BACK : OP_INS_FRONT;
         else op = OP_DELETE;
         if (op == OP_DELETE && recent.size() != 0 && $urandom_range(99) < 80)
            v = recent[$urandom_range(recent.size() - 1)];
         else v = pick_value();
         if (op == OP_INS_FRONT || op == OP_INS_BACK) begin
            recent.push_back(v);
            if (recent.size() > POOL_SIZE) void'(recent.pop_front());
         end
         send_item(op, v);
      end

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.pending() != 0)
         sb.report($sformatf("%0d expected items never arrived", sb.pending()));
      if (sb.errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
